// ===== sv/psr_pkg.sv =====
// shared constants, types and helper functions of the periodic stencil residual block
package psr_pkg;

  localparam int MAX_X  = 16;
  localparam int MAX_Y  = 16;
  localparam int MAX_Z  = 32;
  localparam int DEPTH  = MAX_X * MAX_Y * MAX_Z;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int X_W    = $clog2(MAX_X);
  localparam int Y_W    = $clog2(MAX_Y);
  localparam int Z_W    = $clog2(MAX_Z);
  localparam int RCP_K  = 19;
  localparam int RCP_W  = 20;
  localparam int ACC_W  = 104;

  // input operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CALC = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_SIZE_X = 3'd0;
  localparam logic [2:0] CFG_SIZE_Y = 3'd1;
  localparam logic [2:0] CFG_SIZE_Z = 3'd2;
  localparam logic [2:0] CFG_INV_DX = 3'd3;
  localparam logic [2:0] CFG_INV_DY = 3'd4;
  localparam logic [2:0] CFG_INV_DZ = 3'd5;
  localparam logic [2:0] CFG_JUMP   = 3'd6;

  // decoded configuration seen by front and back
  typedef struct packed {
    logic [4:0]         nx;
    logic [4:0]         ny;
    logic [5:0]         nz;
    logic [9:0]         plane;
    logic [13:0]        ncells;
    logic [IDX_W-1:0]   ref_idx;
    logic [31:0]        inv_x;
    logic [31:0]        inv_y;
    logic [31:0]        inv_z;
    logic signed [31:0] jump;
  } psr_cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        dens;
    logic [31:0]        pot;
    logic [IDX_W-1:0]   a_xp;
    logic [IDX_W-1:0]   a_xm;
    logic [IDX_W-1:0]   a_yp;
    logic [IDX_W-1:0]   a_ym;
    logic [IDX_W-1:0]   a_zp;
    logic [IDX_W-1:0]   a_zm;
    logic               wrap_zp;
    logic               wrap_zm;
    logic               is_ref;
  } psr_cmd_t;

  // size register clamped to 1..max
  function automatic logic [5:0] clamp_size(input logic [5:0] v, input logic [5:0] mx);
    logic [5:0] r;
    if (v == 6'd0) r = 6'd1;
    else if (v > mx) r = mx;
    else r = v;
    return r;
  endfunction

  // ceil(2^19 / d) for d in 1..32, exact quotient for 13-bit numerators
  function automatic logic [RCP_W-1:0] rcp(input logic [5:0] d);
    logic [RCP_W-1:0] r;
    unique case (d)
      6'd1:  r = 20'd524288;
      6'd2:  r = 20'd262144;
      6'd3:  r = 20'd174763;
      6'd4:  r = 20'd131072;
      6'd5:  r = 20'd104858;
      6'd6:  r = 20'd87382;
      6'd7:  r = 20'd74899;
      6'd8:  r = 20'd65536;
      6'd9:  r = 20'd58255;
      6'd10: r = 20'd52429;
      6'd11: r = 20'd47663;
      6'd12: r = 20'd43691;
      6'd13: r = 20'd40330;
      6'd14: r = 20'd37450;
      6'd15: r = 20'd34953;
      6'd16: r = 20'd32768;
      6'd17: r = 20'd30841;
      6'd18: r = 20'd29128;
      6'd19: r = 20'd27595;
      6'd20: r = 20'd26215;
      6'd21: r = 20'd24967;
      6'd22: r = 20'd23832;
      6'd23: r = 20'd22796;
      6'd24: r = 20'd21846;
      6'd25: r = 20'd20972;
      6'd26: r = 20'd20165;
      6'd27: r = 20'd19419;
      6'd28: r = 20'd18725;
      6'd29: r = 20'd18079;
      6'd30: r = 20'd17477;
      6'd31: r = 20'd16913;
      6'd32: r = 20'd16384;
      default: r = 20'd524288;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/psr_front.sv =====
// front end: accepts items, drops out-of-range ones, splits the index and forms neighbor addresses
module psr_front import psr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  psr_cfg_t         cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [12:0]      in_cell_index,
  input  logic [31:0]      in_density,
  input  logic [31:0]      in_potential,
  output logic             push,
  output psr_cmd_t         push_data,
  input  logic             q_full
);

  logic                 adv;
  logic                 in_rng;
  logic [32:0]          prod1;
  logic [32:0]          prod2;
  logic [IDX_W-1:0]     zdiff;
  logic [IDX_W-1:0]     ydiff;

  // stage 1
  logic                 s1_vld_r;
  logic                 s1_op_r;
  logic [IDX_W-1:0]     s1_idx_r;
  logic [31:0]          s1_dens_r;
  logic [31:0]          s1_pot_r;
  logic [IDX_W-1:0]     s1_q1_r;
  // stage 2
  logic                 s2_vld_r;
  logic                 s2_op_r;
  logic [IDX_W-1:0]     s2_idx_r;
  logic [31:0]          s2_dens_r;
  logic [31:0]          s2_pot_r;
  logic [IDX_W-1:0]     s2_q1_r;
  logic [IDX_W-1:0]     s2_q2_r;
  logic [Z_W-1:0]       s2_z_r;
  // stage 3
  logic                 s3_vld_r;
  logic                 s3_op_r;
  logic [IDX_W-1:0]     s3_idx_r;
  logic [31:0]          s3_dens_r;
  logic [31:0]          s3_pot_r;
  logic [X_W-1:0]       s3_x_r;
  logic [Y_W-1:0]       s3_y_r;
  logic [Z_W-1:0]       s3_z_r;
  // stage 4
  logic                 s4_vld_r;
  psr_cmd_t             s4_cmd_r;
  psr_cmd_t             s4_cmd_nxt;

  logic [X_W-1:0]       xp;
  logic [X_W-1:0]       xm;
  logic [Y_W-1:0]       yp;
  logic [Y_W-1:0]       ym;
  logic [Z_W-1:0]       zp;
  logic [Z_W-1:0]       zm;
  logic                 wzp;
  logic                 wzm;

  // linear address of a grid point
  function automatic logic [IDX_W-1:0] addr_of(input logic [X_W-1:0] xx,
                                              input logic [Y_W-1:0] yy,
                                              input logic [Z_W-1:0] zz,
                                              input psr_cfg_t c);
    logic [13:0] a;
    a = 14'(zz) + 14'(c.nz * yy) + 14'(c.plane * xx);
    return a[IDX_W-1:0];
  endfunction

  // whole front advances unless the last stage is blocked by a full queue
  assign adv      = !s4_vld_r || !q_full;
  assign in_ready = adv;
  assign push     = s4_vld_r && !q_full;
  assign push_data = s4_cmd_r;

  // stage 1: range check and first reciprocal multiply
  assign in_rng = {1'b0, in_cell_index} < cfg.ncells;
  assign prod1  = 33'(in_cell_index) * 33'(rcp(cfg.nz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid && in_rng;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= in_op;
      s1_idx_r  <= in_cell_index;
      s1_dens_r <= in_density;
      s1_pot_r  <= in_potential;
      s1_q1_r   <= prod1[RCP_K+IDX_W-1:RCP_K];
    end
  end

  // stage 2: z remainder and second reciprocal multiply
  assign zdiff = s1_idx_r - IDX_W'(s1_q1_r * cfg.nz);
  assign prod2 = 33'(s1_q1_r) * 33'(rcp({1'b0, cfg.ny}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r   <= s1_op_r;
      s2_idx_r  <= s1_idx_r;
      s2_dens_r <= s1_dens_r;
      s2_pot_r  <= s1_pot_r;
      s2_q1_r   <= s1_q1_r;
      s2_q2_r   <= prod2[RCP_K+IDX_W-1:RCP_K];
      s2_z_r    <= zdiff[Z_W-1:0];
    end
  end

  // stage 3: y remainder and x
  assign ydiff = s2_q1_r - IDX_W'(s2_q2_r * cfg.ny);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op_r   <= s2_op_r;
      s3_idx_r  <= s2_idx_r;
      s3_dens_r <= s2_dens_r;
      s3_pot_r  <= s2_pot_r;
      s3_x_r    <= s2_q2_r[X_W-1:0];
      s3_y_r    <= ydiff[Y_W-1:0];
      s3_z_r    <= s2_z_r;
    end
  end

  // stage 4: periodic neighbors and their addresses
  always_comb begin
    wzp = (6'(s3_z_r) + 6'd1) == cfg.nz;
    wzm = s3_z_r == '0;
    xp  = ((5'(s3_x_r) + 5'd1) == cfg.nx) ? '0 : X_W'(s3_x_r + 1'b1);
    xm  = (s3_x_r == '0) ? X_W'(cfg.nx - 5'd1) : X_W'(s3_x_r - 1'b1);
    yp  = ((5'(s3_y_r) + 5'd1) == cfg.ny) ? '0 : Y_W'(s3_y_r + 1'b1);
    ym  = (s3_y_r == '0) ? Y_W'(cfg.ny - 5'd1) : Y_W'(s3_y_r - 1'b1);
    zp  = wzp ? '0 : Z_W'(s3_z_r + 1'b1);
    zm  = wzm ? Z_W'(cfg.nz - 6'd1) : Z_W'(s3_z_r - 1'b1);

    s4_cmd_nxt.op      = s3_op_r;
    s4_cmd_nxt.idx     = s3_idx_r;
    s4_cmd_nxt.dens    = s3_dens_r;
    s4_cmd_nxt.pot     = s3_pot_r;
    s4_cmd_nxt.a_xp    = addr_of(xp, s3_y_r, s3_z_r, cfg);
    s4_cmd_nxt.a_xm    = addr_of(xm, s3_y_r, s3_z_r, cfg);
    s4_cmd_nxt.a_yp    = addr_of(s3_x_r, yp, s3_z_r, cfg);
    s4_cmd_nxt.a_ym    = addr_of(s3_x_r, ym, s3_z_r, cfg);
    s4_cmd_nxt.a_zp    = addr_of(s3_x_r, s3_y_r, zp, cfg);
    s4_cmd_nxt.a_zm    = addr_of(s3_x_r, s3_y_r, zm, cfg);
    s4_cmd_nxt.wrap_zp = wzp;
    s4_cmd_nxt.wrap_zm = wzm;
    s4_cmd_nxt.is_ref  = s3_idx_r == cfg.ref_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_cmd_r <= s4_cmd_nxt;
    end
  end

  // only in-range items get past the first stage
  a_s1_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> ({1'b0, s1_idx_r} < cfg.ncells))
    else $error("front stage holds an out-of-range cell");

endmodule

// ===== sv/psr_queue.sv =====
// short queue between the front and back ends
module psr_queue import psr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  psr_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     q_vld,
  output psr_cmd_t q_data
);

  localparam int QD   = 4;
  localparam int QP_W = $clog2(QD);

  psr_cmd_t         mem_r [QD];
  logic [QP_W-1:0]  wp_r;
  logic [QP_W-1:0]  rp_r;
  logic [QP_W:0]    cnt_r;

  assign full   = cnt_r == (QP_W+1)'(QD);
  assign q_vld  = cnt_r != '0;
  assign q_data = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_vld)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

// ===== sv/psr_back.sv =====
// back end: grid stores, phased neighbor reads and the residual arithmetic pipeline
module psr_back import psr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  psr_cfg_t           cfg,
  input  logic               q_vld,
  input  psr_cmd_t           q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [12:0]        out_result_index,
  output logic signed [63:0] out_residual,
  output logic               out_is_reference
);

  // read phases of one compute
  localparam logic [1:0] PH_C_XP  = 2'd0;
  localparam logic [1:0] PH_XM_YP = 2'd1;
  localparam logic [1:0] PH_YM_ZP = 2'd2;
  localparam logic [1:0] PH_ZM    = 2'd3;

  logic                 adv;
  logic                 calc;
  logic [1:0]           phase_r;
  logic [IDX_W-1:0]     addr_a;
  logic [IDX_W-1:0]     addr_b;

  logic [31:0]          dens_mem [DEPTH];
  logic [31:0]          pot_mem  [DEPTH];

  // read stage
  logic                 d_vld_r;
  logic [1:0]           d_phase_r;
  logic                 d_refa_r;
  logic                 d_refb_r;
  logic [IDX_W-1:0]     d_idx_r;
  logic                 d_isref_r;
  logic                 d_wzp_r;
  logic                 d_wzm_r;
  logic [31:0]          rd_na_r;
  logic [31:0]          rd_nb_r;
  logic [31:0]          rd_pa_r;
  logic [31:0]          rd_pb_r;
  logic signed [31:0]   psi_a;
  logic signed [31:0]   psi_b;

  // gathered neighbors
  logic [31:0]          n_c_r, n_xp_r, n_xm_r, n_yp_r, n_ym_r, n_zp_r;
  logic signed [31:0]   p_c_r, p_xp_r, p_xm_r, p_yp_r, p_ym_r, p_zp_r;

  // arithmetic pipeline
  logic                 m1_vld_r, m2_vld_r, m3_vld_r, m4_vld_r, m5_vld_r, m6_vld_r;
  logic [IDX_W-1:0]     m1_idx_r, m2_idx_r, m3_idx_r, m4_idx_r, m5_idx_r, m6_idx_r;
  logic                 m1_ref_r, m2_ref_r, m3_ref_r, m4_ref_r, m5_ref_r, m6_ref_r;
  logic signed [33:0]   dp_r [3];
  logic signed [33:0]   dm_r [3];
  logic [32:0]          sp_r [3];
  logic [32:0]          sm_r [3];
  logic signed [67:0]   pp_r [3];
  logic signed [67:0]   pm_r [3];
  logic signed [68:0]   t_r  [3];
  logic [66:0]          pl_r [3];
  logic signed [66:0]   ph_r [3];
  logic signed [ACC_W-1:0] term_r [3];
  logic signed [ACC_W-1:0] acc_r;
  logic [31:0]          inv [3];

  logic signed [33:0]   dp_nxt [3];
  logic signed [33:0]   dm_nxt [3];
  logic [32:0]          sp_nxt [3];
  logic [32:0]          sm_nxt [3];
  logic signed [33:0]   jp;
  logic signed [33:0]   jm;
  logic [79:0]          rr;
  logic signed [63:0]   sat;

  logic                 out_vld_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic                 out_ref_r;
  logic signed [63:0]   out_res_r;

  // the whole back end freezes while a result waits
  assign adv  = !out_vld_r || out_ready;
  assign calc = q_vld && (q_data.op == OP_CALC);
  assign pop  = adv && q_vld && ((q_data.op == OP_LOAD) || (phase_r == PH_ZM));

  // phase counter of the compute at the head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_C_XP;
    end else if (adv && calc) begin
      phase_r <= phase_r + 2'd1;
    end
  end

  // read addresses per phase
  always_comb begin
    unique case (phase_r)
      PH_C_XP:  begin addr_a = q_data.idx;  addr_b = q_data.a_xp; end
      PH_XM_YP: begin addr_a = q_data.a_xm; addr_b = q_data.a_yp; end
      PH_YM_ZP: begin addr_a = q_data.a_ym; addr_b = q_data.a_zp; end
      PH_ZM:    begin addr_a = q_data.a_zm; addr_b = q_data.idx;  end
      default:  begin addr_a = q_data.idx;  addr_b = q_data.idx;  end
    endcase
  end

  // store writes from load transactions
  always_ff @(posedge clk) begin
    if (adv && q_vld && (q_data.op == OP_LOAD)) begin
      dens_mem[q_data.idx] <= q_data.dens;
      pot_mem[q_data.idx]  <= q_data.is_ref ? 32'd0 : q_data.pot;
    end
  end

  // two registered read ports on each store
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_na_r <= dens_mem[addr_a];
      rd_nb_r <= dens_mem[addr_b];
      rd_pa_r <= pot_mem[addr_a];
      rd_pb_r <= pot_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= calc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_phase_r <= phase_r;
      d_refa_r  <= addr_a == cfg.ref_idx;
      d_refb_r  <= addr_b == cfg.ref_idx;
      d_idx_r   <= q_data.idx;
      d_isref_r <= q_data.is_ref;
      d_wzp_r   <= q_data.wrap_zp;
      d_wzm_r   <= q_data.wrap_zm;
    end
  end

  // the reference cell always reads as zero potential
  assign psi_a = d_refa_r ? 32'sd0 : $signed(rd_pa_r);
  assign psi_b = d_refb_r ? 32'sd0 : $signed(rd_pb_r);

  // collect neighbors over the first three phases
  always_ff @(posedge clk) begin
    if (adv && d_vld_r) begin
      unique case (d_phase_r)
        PH_C_XP: begin
          n_c_r <= rd_na_r; p_c_r <= psi_a; n_xp_r <= rd_nb_r; p_xp_r <= psi_b;
        end
        PH_XM_YP: begin
          n_xm_r <= rd_na_r; p_xm_r <= psi_a; n_yp_r <= rd_nb_r; p_yp_r <= psi_b;
        end
        PH_YM_ZP: begin
          n_ym_r <= rd_na_r; p_ym_r <= psi_a; n_zp_r <= rd_nb_r; p_zp_r <= psi_b;
        end
        PH_ZM: begin
        end
        default: begin
        end
      endcase
    end
  end

  // potential differences and density sums per axis
  always_comb begin
    jp = d_wzp_r ? 34'(cfg.jump) : 34'sd0;
    jm = d_wzm_r ? 34'(cfg.jump) : 34'sd0;
    dp_nxt[0] = 34'(p_xp_r) - 34'(p_c_r);
    dm_nxt[0] = 34'(p_c_r) - 34'(p_xm_r);
    dp_nxt[1] = 34'(p_yp_r) - 34'(p_c_r);
    dm_nxt[1] = 34'(p_c_r) - 34'(p_ym_r);
    dp_nxt[2] = 34'(p_zp_r) + jp - 34'(p_c_r);
    dm_nxt[2] = 34'(p_c_r) - 34'(psi_a) + jm;
    sp_nxt[0] = 33'(n_xp_r) + 33'(n_c_r);
    sm_nxt[0] = 33'(n_c_r) + 33'(n_xm_r);
    sp_nxt[1] = 33'(n_yp_r) + 33'(n_c_r);
    sm_nxt[1] = 33'(n_c_r) + 33'(n_ym_r);
    sp_nxt[2] = 33'(n_zp_r) + 33'(n_c_r);
    sm_nxt[2] = 33'(n_c_r) + 33'(rd_na_r);
  end

  assign inv[0] = cfg.inv_x;
  assign inv[1] = cfg.inv_y;
  assign inv[2] = cfg.inv_z;

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r  <= 1'b0;
      m2_vld_r  <= 1'b0;
      m3_vld_r  <= 1'b0;
      m4_vld_r  <= 1'b0;
      m5_vld_r  <= 1'b0;
      m6_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      m1_vld_r  <= d_vld_r && (d_phase_r == PH_ZM);
      m2_vld_r  <= m1_vld_r;
      m3_vld_r  <= m2_vld_r;
      m4_vld_r  <= m3_vld_r;
      m5_vld_r  <= m4_vld_r;
      m6_vld_r  <= m5_vld_r;
      out_vld_r <= m6_vld_r;
    end
  end

  // arithmetic stages: flux products, difference, spacing scale, sum
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_idx_r <= d_idx_r;   m1_ref_r <= d_isref_r;
      m2_idx_r <= m1_idx_r;  m2_ref_r <= m1_ref_r;
      m3_idx_r <= m2_idx_r;  m3_ref_r <= m2_ref_r;
      m4_idx_r <= m3_idx_r;  m4_ref_r <= m3_ref_r;
      m5_idx_r <= m4_idx_r;  m5_ref_r <= m4_ref_r;
      m6_idx_r <= m5_idx_r;  m6_ref_r <= m5_ref_r;
      for (int a = 0; a < 3; a++) begin
        dp_r[a]   <= dp_nxt[a];
        dm_r[a]   <= dm_nxt[a];
        sp_r[a]   <= sp_nxt[a];
        sm_r[a]   <= sm_nxt[a];
        pp_r[a]   <= dp_r[a] * $signed({1'b0, sp_r[a]});
        pm_r[a]   <= dm_r[a] * $signed({1'b0, sm_r[a]});
        t_r[a]    <= 69'(pp_r[a]) - 69'(pm_r[a]);
        pl_r[a]   <= 67'(t_r[a][34:0]) * 67'(inv[a]);
        ph_r[a]   <= 67'($signed(t_r[a][68:35]) * $signed({1'b0, inv[a]}));
        term_r[a] <= $signed({{(ACC_W-102){ph_r[a][66]}}, ph_r[a], 35'd0})
                   + $signed({{(ACC_W-67){1'b0}}, pl_r[a]});
      end
      acc_r <= term_r[0] + term_r[1] + term_r[2] + ACC_W'(64'd1 << 23);
    end
  end

  // round to Q40.24 and saturate
  always_comb begin
    rr = acc_r[ACC_W-1:24];
    if (rr[79:63] == {17{rr[79]}}) sat = $signed(rr[63:0]);
    else if (rr[79]) sat = 64'sh8000_0000_0000_0000;
    else sat = 64'sh7FFF_FFFF_FFFF_FFFF;
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r <= m6_idx_r;
      out_ref_r <= m6_ref_r;
      out_res_r <= sat;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result_index = out_idx_r;
  assign out_residual     = out_res_r;
  assign out_is_reference = out_ref_r;

  a_phase_on_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_C_XP) |-> (q_vld && (q_data.op == OP_CALC)))
    else $error("read phase running without a compute at the head");

  a_launch_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && m1_vld_r) |=> !m1_vld_r)
    else $error("two computes launched back to back");

endmodule

// ===== sv/periodic_stencil_residual.sv =====
// top level of the periodic stencil residual block: config registers, front, queue, back
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------------
//  in      | in_valid / in_ready   | in_op, in_cell_index, in_density, in_potential
//  out     | out_valid / out_ready | out_result_index, out_residual, out_is_reference
//  cfg     | cfg_wr_en             | cfg_index, cfg_wdata
//
// a compute runs through 4 read phases in the back end: seven cells are read from each
// store through two read ports, two addresses a cycle unless the back end is frozen;
// a load needs no read phases; out_valid follows 4 front stages including the
// accepting edge, 1 queue write, 4 read phases and 7 math and result stages
// reset is synchronous and clears control only; the stores are not cleared
// a stalled out channel freezes the back end; the 4-entry queue keeps the front taking
// transactions until it fills
module periodic_stencil_residual import psr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [12:0]        in_cell_index,
  input  logic [31:0]        in_density,
  input  logic signed [31:0] in_potential,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [12:0]        out_result_index,
  output logic signed [63:0] out_residual,
  output logic               out_is_reference,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  logic [4:0]         size_x_r;
  logic [4:0]         size_y_r;
  logic [5:0]         size_z_r;
  logic [31:0]        inv_dx_r;
  logic [31:0]        inv_dy_r;
  logic [31:0]        inv_dz_r;
  logic [31:0]        jump_r;
  psr_cfg_t           cfg;
  logic [5:0]         nx6;
  logic [5:0]         ny6;
  logic [5:0]         nz6;
  logic [13:0]        ncells;

  logic               push;
  psr_cmd_t           push_data;
  logic               q_full;
  logic               pop;
  logic               q_vld;
  psr_cmd_t           q_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 5'd16;
      size_y_r <= 5'd16;
      size_z_r <= 6'd32;
      inv_dx_r <= 32'd65536;
      inv_dy_r <= 32'd65536;
      inv_dz_r <= 32'd65536;
      jump_r   <= 32'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_x_r <= cfg_wdata[4:0];
        CFG_SIZE_Y: size_y_r <= cfg_wdata[4:0];
        CFG_SIZE_Z: size_z_r <= cfg_wdata[5:0];
        CFG_INV_DX: inv_dx_r <= cfg_wdata;
        CFG_INV_DY: inv_dy_r <= cfg_wdata;
        CFG_INV_DZ: inv_dz_r <= cfg_wdata;
        CFG_JUMP:   jump_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // decoded grid geometry
  always_comb begin
    nx6        = clamp_size({1'b0, size_x_r}, 6'(MAX_X));
    ny6        = clamp_size({1'b0, size_y_r}, 6'(MAX_Y));
    nz6        = clamp_size(size_z_r, 6'(MAX_Z));
    cfg.nx     = nx6[4:0];
    cfg.ny     = ny6[4:0];
    cfg.nz     = nz6;
    cfg.plane  = 10'(nz6 * ny6);
    ncells     = 14'(cfg.plane * nx6);
    cfg.ncells = ncells;
    cfg.ref_idx = IDX_W'(ncells - 14'd1);
    cfg.inv_x  = inv_dx_r;
    cfg.inv_y  = inv_dy_r;
    cfg.inv_z  = inv_dz_r;
    cfg.jump   = $signed(jump_r);
  end

  psr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_cell_index (in_cell_index),
    .in_density    (in_density),
    .in_potential  (in_potential),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  psr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_vld     (q_vld),
    .q_data    (q_data)
  );

  psr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_vld            (q_vld),
    .q_data           (q_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_index (out_result_index),
    .out_residual     (out_residual),
    .out_is_reference (out_is_reference)
  );

endmodule
